// ===== sv/eop_pkg.sv =====
// Shared types and constants for the even/odd partition block.
`default_nettype none

package eop_pkg;

    // Default capacity of the element store.
    localparam int EOP_MAX_LEN = 64;

    // Width of one element.
    localparam int EOP_DATA_W = 32;

    // One input request: an element and the mark that ends the vector.
    typedef struct packed {
        logic signed [EOP_DATA_W-1:0] value;
        logic                         last;
    } t_in_req;

    // One output request: an element of the partitioned vector.
    typedef struct packed {
        logic signed [EOP_DATA_W-1:0] value_res;
        logic                         last_res;
        logic                         overflowed;
    } t_out_req;

endpackage

`default_nettype wire

// ===== sv/even_odd_partition.sv =====
// Top level of the even/odd partition block: load, in-place partition, emission.
`default_nettype none

// The block collects a vector of signed 32-bit elements, one input request per
// cycle, into an internal store of MAX_LEN entries; the request that carries
// last ends the vector. Elements that arrive once the store is full are
// dropped, and every output request of that vector then carries overflowed.
// The stored vector is partitioned in place with the two-pointer scan: a
// front pointer steps over even elements, a back pointer steps over odd ones,
// and each stuck pair is swapped. The vector is then sent out in order, with
// last_res on its final element. All scanning, swapping and emission go
// through the single read port and single write port of the store RAM, whose
// read is registered. Each swap reads the back element, writes the front
// entry and writes the back entry, then restarts the front scan; emission
// reads each element and loads it into the output register once that is
// free. While the scan and the emission run, the input is stalled; the
// next vector may start loading as soon as the final element sits in the
// output register. No clearing pass runs after reset, since only written
// entries are ever read.
module even_odd_partition
    import eop_pkg::*;
#(
    parameter int MAX_LEN = EOP_MAX_LEN
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    // Input channel.
    input  wire logic     i_in_valid,
    input  wire t_in_req  i_in_req,
    output logic          o_in_stall,
    // Output channel.
    output logic          o_out_valid,
    output t_out_req      o_out_req,
    input  wire logic     i_out_stall
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int CW = $clog2(MAX_LEN + 1);

    typedef enum logic [2:0] {
        S_LOAD,
        S_FRONT_RD,
        S_FRONT_CHK,
        S_BACK_CHK,
        S_SWAP,
        S_EMIT_RD,
        S_EMIT_LD
    } t_state;

    t_state r_state, n_state;

    logic [CW-1:0]         r_fill, n_fill;
    logic                  r_drop, n_drop;
    logic [AW-1:0]         r_front, n_front;
    logic [AW-1:0]         r_back, n_back;
    logic [AW-1:0]         r_last, n_last;
    logic [EOP_DATA_W-1:0] r_fval, n_fval;
    logic                  r_out_valid, n_out_valid;
    t_out_req              r_out, n_out;

    // Store RAM port signals.
    logic                  w_wr_en;
    logic [AW-1:0]         w_wr_addr;
    logic [EOP_DATA_W-1:0] w_wr_data;
    logic                  w_rd_en;
    logic [AW-1:0]         w_rd_addr;
    logic [EOP_DATA_W-1:0] w_rd_data;

    logic                  w_full;
    logic [CW-1:0]         w_fill_after;
    logic [CW-1:0]         w_last_cnt;
    logic [AW-1:0]         w_front_inc;
    logic [AW-1:0]         w_back_dec;
    logic                  w_out_free;

    eop_ram #(
        .WIDTH (EOP_DATA_W),
        .DEPTH (MAX_LEN)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data)
    );

    // The store is full once it holds MAX_LEN elements; a further element is
    // dropped but may still end the vector.
    assign w_full       = (r_fill == CW'(MAX_LEN));
    assign w_fill_after = r_fill + CW'(!w_full);
    assign w_last_cnt   = w_fill_after - CW'(1);
    assign w_front_inc  = r_front + AW'(1);
    assign w_back_dec   = r_back - AW'(1);

    // The output register can take a new element when it is empty or when
    // its current element leaves in this cycle.
    assign w_out_free   = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_fill      = r_fill;
        n_drop      = r_drop;
        n_front     = r_front;
        n_back      = r_back;
        n_last      = r_last;
        n_fval      = r_fval;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        w_wr_en     = 1'b0;
        w_wr_addr   = r_fill[AW-1:0];
        w_wr_data   = i_in_req.value;
        w_rd_en     = 1'b0;
        w_rd_addr   = r_front;

        case (r_state)
            S_LOAD: begin
                if (i_in_valid) begin
                    if (w_full) begin
                        n_drop = 1'b1;
                    end else begin
                        w_wr_en = 1'b1;
                        n_fill  = w_fill_after;
                    end
                    if (i_in_req.last) begin
                        // At least one element is stored whenever last arrives.
                        n_front = '0;
                        n_back  = w_last_cnt[AW-1:0];
                        n_last  = w_last_cnt[AW-1:0];
                        n_state = S_FRONT_RD;
                    end
                end
            end

            S_FRONT_RD: begin
                if (r_front < r_back) begin
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_front;
                    n_state   = S_FRONT_CHK;
                end else begin
                    n_front = '0;
                    n_state = S_EMIT_RD;
                end
            end

            S_FRONT_CHK: begin
                if (!w_rd_data[0]) begin
                    // Even element at the front: step over it and keep scanning.
                    n_front = w_front_inc;
                    if (w_front_inc < r_back) begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = w_front_inc;
                    end else begin
                        n_front = '0;
                        n_state = S_EMIT_RD;
                    end
                end else begin
                    // Odd element stuck at the front: look for an even one at the back.
                    n_fval    = w_rd_data;
                    w_rd_en   = 1'b1;
                    w_rd_addr = r_back;
                    n_state   = S_BACK_CHK;
                end
            end

            S_BACK_CHK: begin
                if (w_rd_data[0]) begin
                    // Odd element at the back: step over it.
                    n_back = w_back_dec;
                    if (r_front < w_back_dec) begin
                        w_rd_en   = 1'b1;
                        w_rd_addr = w_back_dec;
                    end else begin
                        n_front = '0;
                        n_state = S_EMIT_RD;
                    end
                end else begin
                    // Even element at the back: first half of the swap.
                    w_wr_en   = 1'b1;
                    w_wr_addr = r_front;
                    w_wr_data = w_rd_data;
                    n_state   = S_SWAP;
                end
            end

            S_SWAP: begin
                // Second half of the swap, then both pointers move inward.
                w_wr_en   = 1'b1;
                w_wr_addr = r_back;
                w_wr_data = r_fval;
                n_front   = w_front_inc;
                n_back    = w_back_dec;
                n_state   = S_FRONT_RD;
            end

            S_EMIT_RD: begin
                w_rd_en   = 1'b1;
                w_rd_addr = r_front;
                n_state   = S_EMIT_LD;
            end

            S_EMIT_LD: begin
                if (w_out_free) begin
                    n_out_valid      = 1'b1;
                    n_out.value_res  = w_rd_data;
                    n_out.last_res   = (r_front == r_last);
                    n_out.overflowed = r_drop;
                    if (r_front == r_last) begin
                        // Vector done: the store is free for the next one.
                        n_fill  = '0;
                        n_drop  = 1'b0;
                        n_state = S_LOAD;
                    end else begin
                        n_front = w_front_inc;
                        n_state = S_EMIT_RD;
                    end
                end
            end

            default: begin
                n_state = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_front <= n_front;
        r_back  <= n_back;
        r_last  <= n_last;
        r_fval  <= n_fval;
        r_out   <= n_out;
        if (!i_rst_n) begin
            r_state     <= S_LOAD;
            r_fill      <= '0;
            r_drop      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_fill      <= n_fill;
            r_drop      <= n_drop;
            r_out_valid <= n_out_valid;
        end
    end

    // New elements are taken only while the block is loading.
    assign o_in_stall  = (r_state != S_LOAD);
    assign o_out_valid = r_out_valid;
    assign o_out_req   = r_out;

endmodule

`default_nettype wire

// ===== sv/eop_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read.
`default_nettype none

module eop_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // The read data holds until the next read is issued.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire
